/* rtl/stack_machine_executor_top_defines.svh */
// ----------------------------------------------------------------------------
// stack machine executor assertion macros
// shared property forms for the concurrent checks of the top level
// ----------------------------------------------------------------------------
`ifndef STACK_MACHINE_EXECUTOR_TOP_DEFINES_SVH
`define STACK_MACHINE_EXECUTOR_TOP_DEFINES_SVH

// same-cycle implication, reset masks the check
`define SME_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset masks the check
`define SME_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/sme_pkg.sv */
// ----------------------------------------------------------------------------
// sme_pkg
// types, codes and constants shared by the stack machine executor
// ----------------------------------------------------------------------------
package sme_pkg;

	localparam int DEF_STACK_DEPTH = 64;
	localparam int DEF_WORD_WIDTH  = 32;
	localparam int CMD_W           = 4;
	localparam int STATUS_W        = 3;
	localparam int FILL_W          = 7;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH = 4'd0,
		CMD_PALL = 4'd1,
		CMD_PINT = 4'd2,
		CMD_POP  = 4'd3,
		CMD_SWAP = 4'd4,
		CMD_ADD  = 4'd5,
		CMD_NOP  = 4'd6,
		CMD_SUB  = 4'd7,
		CMD_DIV  = 4'd8,
		CMD_MUL  = 4'd9,
		CMD_MOD  = 4'd10
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 3'd0,
		ST_EMPTY   = 3'd1,
		ST_SHORT   = 3'd2,
		ST_DIVZERO = 3'd3,
		ST_FULL    = 3'd4,
		ST_UNKNOWN = 3'd5,
		ST_HALTED  = 3'd6
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_RD_B,
		S_RD_A,
		S_OP,
		S_SWAP,
		S_MDU,
		S_WB,
		S_PINT,
		S_PALL
	} state_t;

	typedef enum logic [1:0] {
		RD_TOP,
		RD_SEC,
		RD_PTR_DEC
	} rd_sel_t;

	typedef enum logic [1:0] {
		WA_PUSH,
		WA_TOP,
		WA_SEC
	} wa_sel_t;

	typedef enum logic [2:0] {
		WD_OPND,
		WD_A,
		WD_B,
		WD_SUM,
		WD_DIFF,
		WD_MDU
	} wd_sel_t;

	typedef enum logic [1:0] {
		MDU_MUL,
		MDU_DIV,
		MDU_MOD
	} mdu_op_t;

	// controller to datapath
	typedef struct packed {
		logic    cap_in;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    wr_en;
		wa_sel_t wa_sel;
		wd_sel_t wd_sel;
		logic    fill_inc;
		logic    fill_dec;
		logic    cap_a;
		logic    cap_b;
		logic    ptr_load;
		logic    ptr_dec;
		logic    mdu_start;
		mdu_op_t mdu_op;
		logic    emit;
		status_t emit_status;
		logic    emit_hv;
		logic    emit_last;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic empty;
		logic full;
		logic lt2;
		logic b_zero;
		logic ptr_zero;
		logic out_free;
		logic mdu_done;
	} dp_stat_t;

endpackage

/* rtl/sme_mdu.sv */
// ----------------------------------------------------------------------------
// sme_mdu
// iterative multiply / divide unit, one bit per cycle
// ----------------------------------------------------------------------------
module sme_mdu
	import sme_pkg::*;
#(
	parameter int WORD_WIDTH = DEF_WORD_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  mdu_op_t               op,
	input  logic [WORD_WIDTH-1:0] a,
	input  logic [WORD_WIDTH-1:0] b,
	output logic                  done,
	output logic [WORD_WIDTH-1:0] result
);

	localparam int W  = WORD_WIDTH;
	localparam int CW = $clog2(W);

	logic          busy_q, fin_q, done_q;
	logic [CW-1:0] cnt_q;
	mdu_op_t       op_q;
	logic          neg_q;
	logic [W-1:0]  acc_q, x_q, y_q, res_q;
	logic [W-1:0]  abs_a, abs_b;
	logic [W:0]    trial;

	assign abs_a = a[W-1] ? (~a + 1'b1) : a;
	assign abs_b = b[W-1] ? (~b + 1'b1) : b;
	assign trial = {acc_q, x_q[W-1]} - {1'b0, y_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				fin_q  <= 1'b0;
				cnt_q  <= CW'(W - 1);
			end else if (busy_q && !fin_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0)
					fin_q <= 1'b1;
			end else if (fin_q) begin
				busy_q <= 1'b0;
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// operands and partial results
	always_ff @(posedge clk) begin
		if (start) begin
			op_q  <= op;
			acc_q <= '0;
			if (op == MDU_MUL) begin
				x_q   <= a;
				y_q   <= b;
				neg_q <= 1'b0;
			end else begin
				x_q   <= abs_a;
				y_q   <= abs_b;
				neg_q <= (op == MDU_DIV) ? (a[W-1] ^ b[W-1]) : a[W-1];
			end
		end else if (busy_q && !fin_q) begin
			if (op_q == MDU_MUL) begin
				// shift-add, low word only
				if (y_q[0])
					acc_q <= acc_q + x_q;
				x_q <= {x_q[W-2:0], 1'b0};
				y_q <= {1'b0, y_q[W-1:1]};
			end else begin
				// restoring division on magnitudes
				if (!trial[W])
					acc_q <= trial[W-1:0];
				else
					acc_q <= {acc_q[W-2:0], x_q[W-1]};
				x_q <= {x_q[W-2:0], ~trial[W]};
			end
		end else if (fin_q) begin
			unique case (op_q)
				MDU_MUL: res_q <= acc_q;
				MDU_DIV: res_q <= neg_q ? (~x_q + 1'b1) : x_q;
				default: res_q <= neg_q ? (~acc_q + 1'b1) : acc_q;
			endcase
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

/* rtl/sme_ctrl.sv */
// ----------------------------------------------------------------------------
// sme_ctrl
// command sequencer: decode, error checks, halt flag and result emission
// ----------------------------------------------------------------------------
module sme_ctrl
	import sme_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [CMD_W-1:0] cmd,
	input  dp_stat_t         stat,
	output ctrl_cmd_t        ctl
);

	state_t state_q, state_d;
	cmd_t   cmd_q;
	logic   halted_q;
	logic   halt_set;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			halted_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (halt_set)
				halted_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.cap_in)
			cmd_q <= cmd_t'(cmd);
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d       = state_q;
		halt_set      = 1'b0;
		ctl           = '0;
		ctl.emit_last = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctl.cap_in = 1'b1;
					state_d    = S_CHECK;
				end
			end
			S_CHECK: begin
				if (halted_q) begin
					if (stat.out_free) begin
						ctl.emit        = 1'b1;
						ctl.emit_status = ST_HALTED;
						state_d         = S_IDLE;
					end
				end else begin
					unique case (cmd_q)
						CMD_PUSH: begin
							if (stat.out_free) begin
								ctl.emit = 1'b1;
								state_d  = S_IDLE;
								if (stat.full) begin
									ctl.emit_status = ST_FULL;
									halt_set        = 1'b1;
								end else begin
									ctl.wr_en    = 1'b1;
									ctl.wa_sel   = WA_PUSH;
									ctl.wd_sel   = WD_OPND;
									ctl.fill_inc = 1'b1;
								end
							end
						end
						CMD_PALL: begin
							if (stat.empty) begin
								if (stat.out_free) begin
									ctl.emit = 1'b1;
									state_d  = S_IDLE;
								end
							end else begin
								ctl.rd_en    = 1'b1;
								ctl.rd_sel   = RD_TOP;
								ctl.ptr_load = 1'b1;
								state_d      = S_PALL;
							end
						end
						CMD_PINT: begin
							if (stat.empty) begin
								if (stat.out_free) begin
									ctl.emit        = 1'b1;
									ctl.emit_status = ST_EMPTY;
									halt_set        = 1'b1;
									state_d         = S_IDLE;
								end
							end else begin
								ctl.rd_en  = 1'b1;
								ctl.rd_sel = RD_TOP;
								state_d    = S_PINT;
							end
						end
						CMD_POP: begin
							if (stat.out_free) begin
								ctl.emit = 1'b1;
								state_d  = S_IDLE;
								if (stat.empty) begin
									ctl.emit_status = ST_EMPTY;
									halt_set        = 1'b1;
								end else begin
									ctl.fill_dec = 1'b1;
								end
							end
						end
						CMD_NOP: begin
							if (stat.out_free) begin
								ctl.emit = 1'b1;
								state_d  = S_IDLE;
							end
						end
						CMD_SWAP, CMD_ADD, CMD_SUB, CMD_DIV, CMD_MUL, CMD_MOD: begin
							if (stat.lt2) begin
								if (stat.out_free) begin
									ctl.emit        = 1'b1;
									ctl.emit_status = ST_SHORT;
									halt_set        = 1'b1;
									state_d         = S_IDLE;
								end
							end else begin
								ctl.rd_en  = 1'b1;
								ctl.rd_sel = RD_TOP;
								state_d    = S_RD_B;
							end
						end
						default: begin
							if (stat.out_free) begin
								ctl.emit        = 1'b1;
								ctl.emit_status = ST_UNKNOWN;
								halt_set        = 1'b1;
								state_d         = S_IDLE;
							end
						end
					endcase
				end
			end
			S_RD_B: begin
				ctl.cap_b  = 1'b1;
				ctl.rd_en  = 1'b1;
				ctl.rd_sel = RD_SEC;
				state_d    = S_RD_A;
			end
			S_RD_A: begin
				ctl.cap_a = 1'b1;
				state_d   = S_OP;
			end
			S_OP: begin
				unique case (cmd_q)
					CMD_SWAP: begin
						ctl.wr_en  = 1'b1;
						ctl.wa_sel = WA_TOP;
						ctl.wd_sel = WD_A;
						state_d    = S_SWAP;
					end
					CMD_ADD, CMD_SUB: begin
						state_d = S_WB;
					end
					CMD_MUL: begin
						ctl.mdu_start = 1'b1;
						ctl.mdu_op    = MDU_MUL;
						state_d       = S_MDU;
					end
					default: begin
						// div or mod
						if (stat.b_zero) begin
							if (stat.out_free) begin
								ctl.emit        = 1'b1;
								ctl.emit_status = ST_DIVZERO;
								halt_set        = 1'b1;
								state_d         = S_IDLE;
							end
						end else begin
							ctl.mdu_start = 1'b1;
							ctl.mdu_op    = (cmd_q == CMD_DIV) ? MDU_DIV : MDU_MOD;
							state_d       = S_MDU;
						end
					end
				endcase
			end
			S_SWAP: begin
				if (stat.out_free) begin
					ctl.wr_en  = 1'b1;
					ctl.wa_sel = WA_SEC;
					ctl.wd_sel = WD_B;
					ctl.emit   = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_MDU: begin
				if (stat.mdu_done)
					state_d = S_WB;
			end
			S_WB: begin
				if (stat.out_free) begin
					ctl.wr_en    = 1'b1;
					ctl.wa_sel   = WA_SEC;
					ctl.fill_dec = 1'b1;
					ctl.emit     = 1'b1;
					state_d      = S_IDLE;
					unique case (cmd_q)
						CMD_ADD: ctl.wd_sel = WD_SUM;
						CMD_SUB: ctl.wd_sel = WD_DIFF;
						default: ctl.wd_sel = WD_MDU;
					endcase
				end
			end
			S_PINT: begin
				if (stat.out_free) begin
					ctl.emit    = 1'b1;
					ctl.emit_hv = 1'b1;
					state_d     = S_IDLE;
				end
			end
			S_PALL: begin
				// one element a cycle while the output is free, top down
				if (stat.out_free) begin
					ctl.emit      = 1'b1;
					ctl.emit_hv   = 1'b1;
					ctl.emit_last = stat.ptr_zero;
					if (stat.ptr_zero) begin
						state_d = S_IDLE;
					end else begin
						ctl.ptr_dec = 1'b1;
						ctl.rd_en   = 1'b1;
						ctl.rd_sel  = RD_PTR_DEC;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

/* rtl/sme_dp.sv */
// ----------------------------------------------------------------------------
// sme_dp
// stack memory, fill count, operand registers, alu and output register
// ----------------------------------------------------------------------------
module sme_dp
	import sme_pkg::*;
#(
	parameter int STACK_DEPTH = DEF_STACK_DEPTH,
	parameter int WORD_WIDTH  = DEF_WORD_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctrl_cmd_t             ctl,
	output dp_stat_t              stat,
	input  logic [WORD_WIDTH-1:0] operand,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [STATUS_W-1:0]   status,
	output logic                  has_value,
	output logic [WORD_WIDTH-1:0] word,
	output logic                  last,
	output logic [FILL_W-1:0]     fill
);

	localparam int W  = WORD_WIDTH;
	localparam int AW = $clog2(STACK_DEPTH);
	localparam int FW = $clog2(STACK_DEPTH + 1);

	logic [W-1:0]  stack_mem_q [STACK_DEPTH];
	logic [W-1:0]  rd_data_q;
	logic [W-1:0]  opnd_q, a_q, b_q;
	logic [FW-1:0] fill_q, fill_d;
	logic [AW-1:0] ptr_q;
	logic [AW-1:0] top_addr, sec_addr, push_addr, rd_addr, wr_addr;
	logic [W-1:0]  wr_data;
	logic          mdu_done;
	logic [W-1:0]  mdu_res;

	logic          out_valid_q;
	status_t       out_status_q;
	logic          out_hv_q, out_last_q;
	logic [W-1:0]  out_word_q;
	logic [FILL_W-1:0] out_fill_q;

	assign top_addr  = AW'(fill_q - FW'(1));
	assign sec_addr  = AW'(fill_q - FW'(2));
	assign push_addr = AW'(fill_q);

	always_comb begin
		unique case (ctl.rd_sel)
			RD_TOP:     rd_addr = top_addr;
			RD_SEC:     rd_addr = sec_addr;
			RD_PTR_DEC: rd_addr = ptr_q - 1'b1;
			default:    rd_addr = top_addr;
		endcase
		unique case (ctl.wa_sel)
			WA_PUSH: wr_addr = push_addr;
			WA_TOP:  wr_addr = top_addr;
			WA_SEC:  wr_addr = sec_addr;
			default: wr_addr = sec_addr;
		endcase
		unique case (ctl.wd_sel)
			WD_OPND: wr_data = opnd_q;
			WD_A:    wr_data = a_q;
			WD_B:    wr_data = b_q;
			WD_SUM:  wr_data = a_q + b_q;
			WD_DIFF: wr_data = a_q - b_q;
			WD_MDU:  wr_data = mdu_res;
			default: wr_data = mdu_res;
		endcase
	end

	// stack memory, registered read
	always_ff @(posedge clk) begin
		if (ctl.wr_en)
			stack_mem_q[wr_addr] <= wr_data;
		if (ctl.rd_en)
			rd_data_q <= stack_mem_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (ctl.cap_in)
			opnd_q <= operand;
		if (ctl.cap_a)
			a_q <= rd_data_q;
		if (ctl.cap_b)
			b_q <= rd_data_q;
		if (ctl.ptr_load)
			ptr_q <= top_addr;
		else if (ctl.ptr_dec)
			ptr_q <= ptr_q - 1'b1;
	end

	always_comb begin
		fill_d = fill_q;
		if (ctl.fill_inc)
			fill_d = fill_q + 1'b1;
		else if (ctl.fill_dec)
			fill_d = fill_q - 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			fill_q <= fill_d;
			if (ctl.emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			out_status_q <= ctl.emit_status;
			out_hv_q     <= ctl.emit_hv;
			out_word_q   <= ctl.emit_hv ? rd_data_q : '0;
			out_last_q   <= ctl.emit_last;
			out_fill_q   <= FILL_W'(fill_d);
		end
	end

	sme_mdu #(
		.WORD_WIDTH (W)
	) u_mdu (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl.mdu_start),
		.op     (ctl.mdu_op),
		.a      (a_q),
		.b      (b_q),
		.done   (mdu_done),
		.result (mdu_res)
	);

	assign stat.empty    = (fill_q == '0);
	assign stat.full     = (fill_q == FW'(STACK_DEPTH));
	assign stat.lt2      = (fill_q < FW'(2));
	assign stat.b_zero   = (b_q == '0);
	assign stat.ptr_zero = (ptr_q == '0);
	assign stat.out_free = !out_valid_q || out_ready;
	assign stat.mdu_done = mdu_done;

	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign has_value = out_hv_q;
	assign word      = out_word_q;
	assign last      = out_last_q;
	assign fill      = out_fill_q;

endmodule

/* rtl/stack_machine_executor_top.sv */
// ----------------------------------------------------------------------------
// stack_machine_executor_top
// bounded stack calculator: push, pall, pint, pop, swap, add, nop, sub, div,
// mul and mod on signed words, with error codes and a sticky halt
// ----------------------------------------------------------------------------
// one command at a time, the next taken once the sequencer is idle; mul, div and
//   mod run in the shift-add / restoring unit at one bit per cycle
// pall: one element per cycle through the single read port unless output stalls
// reset: fill count and halt flag cleared, stack contents left as they are
`include "stack_machine_executor_top_defines.svh"

module stack_machine_executor_top
	import sme_pkg::*;
#(
	parameter int STACK_DEPTH = DEF_STACK_DEPTH,
	parameter int WORD_WIDTH  = DEF_WORD_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// command channel
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [CMD_W-1:0]      cmd,
	input  logic [WORD_WIDTH-1:0] operand,
	// result channel
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [STATUS_W-1:0]   status,
	output logic                  has_value,
	output logic [WORD_WIDTH-1:0] word,
	output logic                  last,
	output logic [FILL_W-1:0]     fill
);

	// command and status bundles between sequencer and datapath
	ctrl_cmd_t ctl;
	dp_stat_t  stat;

	// sequencer: decodes the command, checks stack bounds, owns the halt flag
	// and decides when a result word is loaded into the output register
	sme_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.stat     (stat),
		.ctl      (ctl)
	);

	// datapath: stack memory, fill count, operand registers, arithmetic and
	// the output register that lets the result wait while the next word comes in
	sme_dp #(
		.STACK_DEPTH (STACK_DEPTH),
		.WORD_WIDTH  (WORD_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.stat      (stat),
		.operand   (operand),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.has_value (has_value),
		.word      (word),
		.last      (last),
		.fill      (fill)
	);

	// fill reported with a result never exceeds the stack depth
	`SME_ASSERT_IMP(a_fill_bound, out_valid, fill <= FILL_W'(STACK_DEPTH), "fill beyond depth")
	// only a successful pint or pall carries a stack element
	`SME_ASSERT_IMP(a_value_ok, out_valid && has_value, status == ST_OK, "value on error word")
	// failed commands give a single closing word
	`SME_ASSERT_IMP(a_err_last, out_valid && status != ST_OK, last && !has_value, "error not last")
	// one command in flight: the sequencer leaves idle on every accept
	`SME_ASSERT_NXT(a_one_cmd, in_valid && in_ready, !in_ready, "second command taken")

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb: stack machine executor testbench
// drives command words through the valid/ready input channel and checks every
// result word against a cycle-free shadow of the stack, with random idling
// on both channels; the run ends with one randomly chosen fault that halts
// the machine, followed by commands that must all report the halt
// ----------------------------------------------------------------------------
module tb;
	import sme_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STACK_N = DEF_STACK_DEPTH;
	localparam int WORD_W  = DEF_WORD_WIDTH;
	// command codes past mod are undefined and must be refused
	localparam int UNKNOWN_LO = int'(CMD_MOD) + 1;
	localparam int UNKNOWN_HI = (1 << CMD_W) - 1;
	localparam int RANDOM_ITEMS = 40;

	// one result word as the checker sees it
	typedef struct packed {
		status_t             status;
		logic                has_value;
		logic [WORD_W-1:0]   value;
		logic                last;
		logic [FILL_W-1:0]   fill;
	} res_word_t;

	// one row of the directed script; want is used only when typed is set
	typedef struct packed {
		logic [CMD_W-1:0]  op;
		logic [WORD_W-1:0] arg;
		logic              typed;
		res_word_t         want;
	} script_row_t;

	// clock, reset and the block's ports
	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [CMD_W-1:0]    cmd = '0;
	logic [WORD_W-1:0]   operand = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [STATUS_W-1:0] status;
	logic                has_value;
	logic [WORD_W-1:0]   word;
	logic                last;
	logic [FILL_W-1:0]   fill;

	// shadow copy of the machine state
	logic [WORD_W-1:0] shadow_stack [STACK_N];
	int                shadow_fill = 0;
	bit                shadow_halt = 1'b0;

	// words the block owes us, oldest first, and the words of the latest command
	res_word_t predicted_words [$];
	res_word_t step_words [$];

	int mismatches = 0;
	bit send_calm = 1'b0;
	bit take_calm = 1'b0;

	// directed script: pall on an empty stack, extremes, every operation,
	// signed division overflow and mod with a negative dividend
	script_row_t script [25] = '{
		'{CMD_PALL, 32'h0,        1'b1, '{ST_OK, 1'b0, 32'h0,        1'b1, 7'd0}},
		'{CMD_NOP,  32'h0,        1'b1, '{ST_OK, 1'b0, 32'h0,        1'b1, 7'd0}},
		'{CMD_PUSH, 32'h7fffffff, 1'b1, '{ST_OK, 1'b0, 32'h0,        1'b1, 7'd1}},
		'{CMD_PUSH, 32'h80000000, 1'b1, '{ST_OK, 1'b0, 32'h0,        1'b1, 7'd2}},
		'{CMD_PINT, 32'h0,        1'b1, '{ST_OK, 1'b1, 32'h80000000, 1'b1, 7'd2}},
		'{CMD_SWAP, 32'h0,        1'b0, '0},
		'{CMD_PALL, 32'h0,        1'b0, '0},
		'{CMD_ADD,  32'h0,        1'b0, '0},
		'{CMD_PUSH, 32'hffffffff, 1'b1, '{ST_OK, 1'b0, 32'h0,        1'b1, 7'd2}},
		'{CMD_MUL,  32'h0,        1'b0, '0},
		'{CMD_PUSH, 32'h80000000, 1'b0, '0},
		'{CMD_PUSH, 32'hffffffff, 1'b0, '0},
		'{CMD_DIV,  32'h0,        1'b0, '0},
		'{CMD_PINT, 32'h0,        1'b0, '0},
		'{CMD_PUSH, 32'hffffffff, 1'b0, '0},
		'{CMD_MOD,  32'h0,        1'b0, '0},
		'{CMD_PUSH, 32'hfffffff9, 1'b0, '0},
		'{CMD_PUSH, 32'h2,        1'b0, '0},
		'{CMD_MOD,  32'h0,        1'b0, '0},
		'{CMD_PUSH, 32'hfffffffe, 1'b0, '0},
		'{CMD_DIV,  32'h0,        1'b0, '0},
		'{CMD_SUB,  32'h0,        1'b0, '0},
		'{CMD_POP,  32'h0,        1'b0, '0},
		'{CMD_POP,  32'h0,        1'b0, '0},
		'{CMD_PALL, 32'h0,        1'b1, '{ST_OK, 1'b0, 32'h0,        1'b1, 7'd0}}
	};

	cmd_t binary_ops [6] = '{CMD_SWAP, CMD_ADD, CMD_SUB, CMD_DIV, CMD_MUL, CMD_MOD};

	stack_machine_executor_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.operand   (operand),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.has_value (has_value),
		.word      (word),
		.last      (last),
		.fill      (fill)
	);

	always #2 clk = ~clk;

	// idle cycles before the next word; now and then flips into a calm
	// stretch with no idling at all
	function automatic int draw_gap(inout bit calm);
		if ($urandom_range(0, 19) == 0)
			calm = !calm;
		return calm ? 0 : int'($urandom_range(0, 9));
	endfunction

	function automatic void note_word(status_t st, logic hv, logic [WORD_W-1:0] v,
			logic lst);
		res_word_t w;
		w.status    = st;
		w.has_value = hv;
		w.value     = hv ? v : '0;
		w.last      = lst;
		w.fill      = FILL_W'(shadow_fill);
		step_words.push_back(w);
	endfunction

	// advance the shadow machine by one command and collect the words it owes
	task automatic execute_cmd(input logic [CMD_W-1:0] op, input logic [WORD_W-1:0] arg);
		logic [WORD_W-1:0] lhs, rhs, res;
		longint            slhs, srhs;
		status_t           fault;
		step_words.delete();
		fault = ST_OK;
		if (shadow_halt) begin
			note_word(ST_HALTED, 1'b0, '0, 1'b1);
			return;
		end
		case (op)
			CMD_PUSH: begin
				if (shadow_fill >= STACK_N) begin
					fault = ST_FULL;
				end else begin
					shadow_stack[shadow_fill] = arg;
					shadow_fill++;
				end
			end
			CMD_PALL: begin
				// top down, last mark on the bottom element
				if (shadow_fill == 0) begin
					note_word(ST_OK, 1'b0, '0, 1'b1);
				end else begin
					for (int i = 0; i < shadow_fill; i++)
						note_word(ST_OK, 1'b1, shadow_stack[shadow_fill-1-i],
							i == shadow_fill - 1);
				end
				return;
			end
			CMD_PINT: begin
				if (shadow_fill == 0) begin
					fault = ST_EMPTY;
				end else begin
					note_word(ST_OK, 1'b1, shadow_stack[shadow_fill-1], 1'b1);
					return;
				end
			end
			CMD_POP: begin
				if (shadow_fill == 0)
					fault = ST_EMPTY;
				else
					shadow_fill--;
			end
			CMD_NOP: ;
			CMD_SWAP, CMD_ADD, CMD_SUB, CMD_DIV, CMD_MUL, CMD_MOD: begin
				if (shadow_fill < 2) begin
					fault = ST_SHORT;
				end else begin
					rhs = shadow_stack[shadow_fill-1];
					lhs = shadow_stack[shadow_fill-2];
					slhs = longint'($signed(lhs));
					srhs = longint'($signed(rhs));
					if (op == CMD_SWAP) begin
						shadow_stack[shadow_fill-1] = lhs;
						shadow_stack[shadow_fill-2] = rhs;
					end else if ((op == CMD_DIV || op == CMD_MOD) && rhs == '0) begin
						fault = ST_DIVZERO;
					end else begin
						// 64-bit quotient keeps the most negative / -1 case
						// clean; the low half wraps as the block does
						case (op)
							CMD_ADD: res = lhs + rhs;
							CMD_SUB: res = lhs - rhs;
							CMD_MUL: res = lhs * rhs;
							CMD_DIV: res = WORD_W'(slhs / srhs);
							default: res = WORD_W'(slhs % srhs);
						endcase
						shadow_stack[shadow_fill-2] = res;
						shadow_fill--;
					end
				end
			end
			default: fault = ST_UNKNOWN;
		endcase
		if (fault != ST_OK)
			shadow_halt = 1'b1;
		note_word(fault, 1'b0, '0, 1'b1);
	endtask

	// offer one command word and hold it until taken; valid is only dropped
	// when an idle gap follows, so it never falls and rises in one step
	task automatic send(input logic [CMD_W-1:0] op, input logic [WORD_W-1:0] arg,
			input logic typed = 1'b0, input res_word_t want = '0);
		int gap;
		gap = draw_gap(send_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd      <= op;
		operand  <= arg;
		do @(posedge clk); while (!in_ready);
		execute_cmd(op, arg);
		if (typed)
			predicted_words.push_back(want);
		else
			foreach (step_words[i])
				predicted_words.push_back(step_words[i]);
	endtask

	// operands: extremes, small signed values for useful quotients, and noise
	function automatic logic [WORD_W-1:0] pick_operand();
		case ($urandom_range(0, 5))
			0: begin
				case ($urandom_range(0, 4))
					0: return 32'h0;
					1: return 32'hffffffff;
					2: return 32'h1;
					3: return 32'h7fffffff;
					default: return 32'h80000000;
				endcase
			end
			1, 2: return WORD_W'(int'($urandom_range(0, 40)) - 20);
			default: return $urandom();
		endcase
	endfunction

	// a random command that the current stack accepts without a fault
	function automatic cmd_t pick_legal_cmd();
		int   r;
		cmd_t c;
		r = $urandom_range(0, 99);
		if      (r < 30) c = CMD_PUSH;
		else if (r < 34) c = CMD_PALL;
		else if (r < 42) c = CMD_PINT;
		else if (r < 52) c = CMD_POP;
		else if (r < 58) c = CMD_SWAP;
		else if (r < 62) c = CMD_NOP;
		else if (r < 69) c = CMD_ADD;
		else if (r < 76) c = CMD_SUB;
		else if (r < 83) c = CMD_MUL;
		else if (r < 91) c = CMD_DIV;
		else             c = CMD_MOD;
		if ((c == CMD_PINT || c == CMD_POP) && shadow_fill == 0)
			c = CMD_PUSH;
		if (c inside {CMD_SWAP, CMD_ADD, CMD_SUB, CMD_DIV, CMD_MUL, CMD_MOD}
				&& shadow_fill < 2)
			c = CMD_PUSH;
		if ((c == CMD_DIV || c == CMD_MOD) && shadow_stack[shadow_fill-1] == '0)
			c = CMD_ADD;
		if (c == CMD_PUSH && shadow_fill >= STACK_N)
			c = CMD_POP;
		return c;
	endfunction

	// result side: random stalls, every taken word compared with the oldest
	// prediction field by field
	task automatic check_field(input string name, input logic [WORD_W-1:0] want,
			input logic [WORD_W-1:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t ns: %s mismatch, expected %0h, actual %0h",
				$time, name, want, got);
		end
	endtask

	initial begin
		int        stall;
		res_word_t due;
		wait (arst_n);
		forever begin
			stall = draw_gap(take_calm);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			if (predicted_words.size() == 0) begin
				mismatches++;
				$display("%0t ns: unexpected result word, status %0d, word %0h",
					$time, status, word);
			end else begin
				due = predicted_words.pop_front();
				check_field("status", WORD_W'(due.status), WORD_W'(status));
				check_field("has_value", WORD_W'(due.has_value), WORD_W'(has_value));
				check_field("word", due.value, word);
				check_field("last", WORD_W'(due.last), WORD_W'(last));
				check_field("fill", WORD_W'(due.fill), WORD_W'(fill));
			end
		end
	end

	// stimulus
	initial begin
		status_t fault;
		foreach (shadow_stack[i])
			shadow_stack[i] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed script
		foreach (script[i])
			send(script[i].op, script[i].arg, script[i].typed, script[i].want);

		// random well-formed traffic, with one climb to a full stack and a
		// pall of all of it part way through
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS / 2) begin
				while (shadow_fill < STACK_N)
					send(CMD_PUSH, pick_operand());
				send(CMD_PALL, pick_operand());
			end
			send(pick_legal_cmd(), pick_operand());
		end

		// one fault to close the run, chosen at random since it halts for good
		fault = status_t'($urandom_range(int'(ST_EMPTY), int'(ST_UNKNOWN)));
		case (fault)
			ST_EMPTY: begin
				while (shadow_fill > 0)
					send(CMD_POP, pick_operand());
				send($urandom_range(0, 1) ? CMD_PINT : CMD_POP, pick_operand());
			end
			ST_SHORT: begin
				while (shadow_fill > int'($urandom_range(0, 1)))
					send(CMD_POP, pick_operand());
				send(binary_ops[$urandom_range(0, 5)], pick_operand());
			end
			ST_DIVZERO: begin
				send(CMD_PUSH, pick_operand());
				send(CMD_PUSH, '0);
				send($urandom_range(0, 1) ? CMD_DIV : CMD_MOD, pick_operand());
			end
			ST_FULL: begin
				while (shadow_fill < STACK_N)
					send(CMD_PUSH, pick_operand());
				send(CMD_PUSH, pick_operand());
			end
			default: send(CMD_W'($urandom_range(UNKNOWN_LO, UNKNOWN_HI)), $urandom());
		endcase

		// halted: nop and everything else must come back refused
		send(CMD_NOP, '0);
		send(CMD_PALL, '0);
		repeat (12) send(CMD_W'($urandom_range(0, UNKNOWN_HI)), $urandom());

		in_valid <= 1'b0;
		while (predicted_words.size() != 0)
			@(posedge clk);
		// room for a stray extra word to show up
		repeat (WORD_W + 16) @(posedge clk);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

/* stack_machine_executor_top.f */
+incdir+rtl
rtl/sme_pkg.sv
rtl/sme_mdu.sv
rtl/sme_ctrl.sv
rtl/sme_dp.sv
rtl/stack_machine_executor_top.sv
bench/tb.sv
